>>> rtl/csp_pkg.sv
// Shared types, codes and letter tables for the command stream parser.
package csp_pkg;

   typedef enum logic [3:0] {
      MODE_COMMAND = 4'b0001,
      MODE_LENGTH  = 4'b0010,
      MODE_PAYLOAD = 4'b0100,
      MODE_ERROR   = 4'b1000
   } mode_type;

   typedef logic [1:0] event_kind_type;

   localparam event_kind_type EV_PAYLOAD = 2'd0;
   localparam event_kind_type EV_TOGGLE  = 2'd1;
   localparam event_kind_type EV_EMPTY   = 2'd2;
   localparam event_kind_type EV_ERROR   = 2'd3;

   localparam logic [7:0] CHAR_UPPER_A = "A";
   localparam logic [7:0] CHAR_UPPER_Z = "Z";
   localparam logic [7:0] CHAR_ZERO    = "0";
   localparam logic [7:0] CHAR_NINE    = "9";
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // letters in a command word, and the saturation point of the letter count
   localparam logic [2:0] WORD_SIZE  = 3'd6;
   localparam logic [2:0] WORD_LIMIT = 3'd7;

   function automatic logic [7:0] update_letter(input logic [2:0] idx);
      logic [7:0] letter;
      unique case (idx)
         3'd0:    letter = "U";
         3'd1:    letter = "P";
         3'd2:    letter = "D";
         3'd3:    letter = "A";
         3'd4:    letter = "T";
         3'd5:    letter = "E";
         default: letter = 8'h00;
      endcase
      return letter;
   endfunction

   function automatic logic [7:0] toggle_letter(input logic [2:0] idx);
      logic [7:0] letter;
      unique case (idx)
         3'd0:    letter = "T";
         3'd1:    letter = "O";
         3'd2:    letter = "G";
         3'd3:    letter = "G";
         3'd4:    letter = "L";
         3'd5:    letter = "E";
         default: letter = 8'h00;
      endcase
      return letter;
   endfunction

endpackage

>>> rtl/command_stream_parser.sv
// Command stream parser: words, decimal length and payload pass-through.
// A result is registered and appears on rsp_ in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the only hold-off is a stalled result
// register, the length update being one shift-add and compare per byte.
// Reset (synchronous, active high) returns to command mode, clears the word
// tracking and the length, and empties the result register.
module command_stream_parser #(
   parameter int LENGTH_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   localparam logic [LENGTH_BITS-1:0] CountMax   = {LENGTH_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] CountTenth = CountMax / 10;

   csp_pkg::mode_type       mode_ff, mode_in;
   logic [2:0]              word_length_ff, word_length_in;
   logic                    may_be_update_ff, may_be_update_in;
   logic                    may_be_toggle_ff, may_be_toggle_in;
   logic [LENGTH_BITS-1:0]  byte_count_ff, byte_count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   csp_pkg::event_kind_type rsp_kind_ff;
   logic [7:0]              rsp_byte_ff;
   logic                    rsp_last_ff;

   logic                    accept;
   logic                    fire;
   csp_pkg::event_kind_type fire_kind;
   logic [7:0]              fire_byte;
   logic                    fire_last;

   logic                    is_letter;
   logic                    is_digit;
   logic [3:0]              digit;
   logic [LENGTH_BITS-1:0]  times_ten;
   logic [LENGTH_BITS:0]    length_sum;

   // hold the input only while a finished result waits and is stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign is_letter  = (req_in_byte >= csp_pkg::CHAR_UPPER_A) &&
                       (req_in_byte <= csp_pkg::CHAR_UPPER_Z);
   assign is_digit   = (req_in_byte >= csp_pkg::CHAR_ZERO) &&
                       (req_in_byte <= csp_pkg::CHAR_NINE);
   assign digit      = 4'(req_in_byte - csp_pkg::CHAR_ZERO);
   // the product may wrap once the count exceeds a tenth of the limit; the compare below then flags an error
   assign times_ten  = (byte_count_ff << 3) + (byte_count_ff << 1);
   assign length_sum = {1'b0, times_ten} + (LENGTH_BITS + 1)'(digit);

   always_comb begin
      mode_in          = mode_ff;
      word_length_in   = word_length_ff;
      may_be_update_in = may_be_update_ff;
      may_be_toggle_in = may_be_toggle_ff;
      byte_count_in    = byte_count_ff;
      fire             = 1'b0;
      fire_kind        = csp_pkg::EV_PAYLOAD;
      fire_byte        = 8'h00;
      fire_last        = 1'b0;
      if (accept) begin
         unique case (mode_ff)
            csp_pkg::MODE_COMMAND: begin
               if (is_letter) begin
                  if (word_length_ff < csp_pkg::WORD_SIZE) begin
                     if (csp_pkg::update_letter(word_length_ff) != req_in_byte) begin
                        may_be_update_in = 1'b0;
                     end
                     if (csp_pkg::toggle_letter(word_length_ff) != req_in_byte) begin
                        may_be_toggle_in = 1'b0;
                     end
                  end else begin
                     may_be_update_in = 1'b0;
                     may_be_toggle_in = 1'b0;
                  end
                  if (word_length_ff != csp_pkg::WORD_LIMIT) begin
                     word_length_in = word_length_ff + 3'd1;
                  end
               end else begin
                  // end of word: restart tracking, act on a full match
                  word_length_in   = 3'd0;
                  may_be_update_in = 1'b1;
                  may_be_toggle_in = 1'b1;
                  if (word_length_ff == csp_pkg::WORD_SIZE && may_be_update_ff) begin
                     mode_in       = csp_pkg::MODE_LENGTH;
                     byte_count_in = '0;
                  end else if (word_length_ff == csp_pkg::WORD_SIZE &&
                               may_be_toggle_ff) begin
                     fire      = 1'b1;
                     fire_kind = csp_pkg::EV_TOGGLE;
                  end
               end
            end
            csp_pkg::MODE_LENGTH: begin
               if (is_digit) begin
                  if (byte_count_ff > CountTenth || length_sum[LENGTH_BITS]) begin
                     mode_in   = csp_pkg::MODE_ERROR;
                     fire      = 1'b1;
                     fire_kind = csp_pkg::EV_ERROR;
                  end else begin
                     byte_count_in = length_sum[LENGTH_BITS-1:0];
                  end
               end else if (req_in_byte == csp_pkg::CHAR_NEWLINE) begin
                  if (byte_count_ff == '0) begin
                     mode_in   = csp_pkg::MODE_COMMAND;
                     fire      = 1'b1;
                     fire_kind = csp_pkg::EV_EMPTY;
                  end else begin
                     mode_in = csp_pkg::MODE_PAYLOAD;
                  end
               end else begin
                  mode_in   = csp_pkg::MODE_ERROR;
                  fire      = 1'b1;
                  fire_kind = csp_pkg::EV_ERROR;
               end
            end
            csp_pkg::MODE_PAYLOAD: begin
               fire      = 1'b1;
               fire_kind = csp_pkg::EV_PAYLOAD;
               fire_byte = req_in_byte;
               if (byte_count_ff != '0) begin
                  byte_count_in = byte_count_ff - LENGTH_BITS'(1);
               end
               if (byte_count_ff <= LENGTH_BITS'(1)) begin
                  fire_last = 1'b1;
                  mode_in   = csp_pkg::MODE_COMMAND;
               end
            end
            default: begin
               fire      = 1'b1;
               fire_kind = csp_pkg::EV_ERROR;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = fire;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= csp_pkg::MODE_COMMAND;
         word_length_ff   <= 3'd0;
         may_be_update_ff <= 1'b1;
         may_be_toggle_ff <= 1'b1;
         byte_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         mode_ff          <= mode_in;
         word_length_ff   <= word_length_in;
         may_be_update_ff <= may_be_update_in;
         may_be_toggle_ff <= may_be_toggle_in;
         byte_count_ff    <= byte_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && fire) begin
         rsp_kind_ff <= fire_kind;
         rsp_byte_ff <= fire_byte;
         rsp_last_ff <= fire_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;

   // error mode is sticky until reset
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == csp_pkg::MODE_ERROR |=> mode_ff == csp_pkg::MODE_ERROR)
      else $error("parser left error mode without reset");

   // payload mode always has bytes still to come
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff == csp_pkg::MODE_PAYLOAD |-> byte_count_ff != '0)
      else $error("payload mode with zero byte count");

   // only payload items carry a byte or the last mark
   a_nonpayload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != csp_pkg::EV_PAYLOAD |->
         rsp_byte_ff == 8'h00 && !rsp_last_ff)
      else $error("non-payload item carries byte or last");

   // the last payload byte always returns the parser to command mode
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      accept && fire && fire_last |=> mode_ff == csp_pkg::MODE_COMMAND)
      else $error("last payload byte did not return to command mode");

   // input is held off only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled with no waiting result");

endmodule
